[rtl/line_segment_clipper_macros.svh]
// ---------------------------------------------------------------------------
// Line segment clipper assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef LINE_SEGMENT_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_CLIPPER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lsc_pkg.sv]
// ---------------------------------------------------------------------------
// Line segment clipper package
// Shared constants, register map and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int CoordWidthDef = 16;
  localparam int AddrW         = 4;
  localparam int DataW         = 32;
  localparam int PassCntW      = 4;

  // Give up after this many intersection passes.
  localparam logic [PassCntW-1:0] PassLimit = 4'd8;

  // Outcode bits.
  localparam logic [3:0] OcLeft   = 4'b0001;
  localparam logic [3:0] OcRight  = 4'b0010;
  localparam logic [3:0] OcBottom = 4'b0100;
  localparam logic [3:0] OcTop    = 4'b1000;

  // Window reset values.
  localparam int WinLeftRst   = 100;
  localparam int WinBottomRst = 100;
  localparam int WinRightRst  = 300;
  localparam int WinTopRst    = 300;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } lsc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } lsc_state_e;

endpackage

`default_nettype wire

[rtl/line_segment_clipper.sv]
// ---------------------------------------------------------------------------
// Line segment clipper
// Cohen-Sutherland clipping of one segment against a programmable window.
// ---------------------------------------------------------------------------
// One segment is taken at a time; in_stall_o stays high from acceptance until
// the result word is loaded into the output register. Each clip pass runs
// CODE, SETUP, MUL, 2*COORD_WIDTH divide steps and APPLY; the divide steps
// are skipped when the divisor is zero. The restoring divider yields one
// quotient bit per cycle. A segment needs up to four passes with a proper
// window (up to eight with an inverted one), plus a final outcode check in
// CODE and a FINISH state that waits for the output register to be free.
// Rejected segments report zero coordinates. Window registers sit on the
// APB port at 0x0 (left), 0x4 (bottom), 0x8 (right) and 0xC (top); write
// them only while idle.
`default_nettype none

module line_segment_clipper #(
  parameter int COORD_WIDTH = lsc_pkg::CoordWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // APB configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [lsc_pkg::AddrW-1:0]    paddr,
  input  wire  [lsc_pkg::DataW-1:0]    pwdata,
  output logic [lsc_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  // segment input channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [COORD_WIDTH-1:0] start_x_i,
  input  wire  signed [COORD_WIDTH-1:0] start_y_i,
  input  wire  signed [COORD_WIDTH-1:0] end_x_i,
  input  wire  signed [COORD_WIDTH-1:0] end_y_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         accepted_o,
  output logic signed [COORD_WIDTH-1:0] clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0] clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0] clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0] clipped_end_y_o
);

`include "line_segment_clipper_macros.svh"

  localparam int W    = COORD_WIDTH;
  localparam int PW   = 2 * W;
  localparam int CntW = $clog2(PW);

  localparam logic signed [W-1:0] CoordMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CoordMin = {1'b1, {(W-1){1'b0}}};

  // -------------------------------------------------------------------------
  // Window registers
  // -------------------------------------------------------------------------
  logic signed [W-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
  logic                cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= W'(lsc_pkg::WinLeftRst);
      win_bottom_q <= W'(lsc_pkg::WinBottomRst);
      win_right_q  <= W'(lsc_pkg::WinRightRst);
      win_top_q    <= W'(lsc_pkg::WinTopRst);
    end else if (cfg_wr) begin
      case (lsc_pkg::lsc_reg_e'(paddr[3:2]))
        lsc_pkg::REG_LEFT:   win_left_q   <= pwdata[W-1:0];
        lsc_pkg::REG_BOTTOM: win_bottom_q <= pwdata[W-1:0];
        lsc_pkg::REG_RIGHT:  win_right_q  <= pwdata[W-1:0];
        lsc_pkg::REG_TOP:    win_top_q    <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended to the bus width.
  always_comb begin
    case (lsc_pkg::lsc_reg_e'(paddr[3:2]))
      lsc_pkg::REG_LEFT:   prdata = lsc_pkg::DataW'(win_left_q);
      lsc_pkg::REG_BOTTOM: prdata = lsc_pkg::DataW'(win_bottom_q);
      lsc_pkg::REG_RIGHT:  prdata = lsc_pkg::DataW'(win_right_q);
      lsc_pkg::REG_TOP:    prdata = lsc_pkg::DataW'(win_top_q);
      default:             prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer and shared datapath registers
  // -------------------------------------------------------------------------
  lsc_pkg::lsc_state_e state_q, state_d;

  logic signed [W-1:0]           x1_q, y1_q, x2_q, y2_q;
  logic signed [W-1:0]           x1_d, y1_d, x2_d, y2_d;
  logic [3:0]                    edge_q, edge_d;
  logic                          first_q, first_d;
  logic                          acc_q, acc_d;
  logic [lsc_pkg::PassCntW-1:0]  pass_q, pass_d;
  logic [W-1:0]                  mag_a_q, mag_a_d, mag_b_q, mag_b_d, den_q, den_d;
  logic                          neg_q, neg_d;
  logic [PW-1:0]                 div_q, div_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [CntW-1:0]               cnt_q, cnt_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q, out_acc_d;
  logic signed [W-1:0]           out_sx_q, out_sy_q, out_ex_q, out_ey_q;
  logic signed [W-1:0]           out_sx_d, out_sy_d, out_ex_d, out_ey_d;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y,
                                         input logic signed [W-1:0] wl,
                                         input logic signed [W-1:0] wr,
                                         input logic signed [W-1:0] wb,
                                         input logic signed [W-1:0] wt);
    logic [3:0] c;
    c = '0;
    if (x < wl)      c |= lsc_pkg::OcLeft;
    else if (x > wr) c |= lsc_pkg::OcRight;
    if (y < wb)      c |= lsc_pkg::OcBottom;
    else if (y > wt) c |= lsc_pkg::OcTop;
    return c;
  endfunction

  // Combinational helpers
  logic [3:0]          c1, c2, co;
  logic                horiz;
  logic signed [W-1:0] edge_val, base;
  logic signed [W:0]   dx, dy, dn, d_sel, q_sel;
  logic [W:0]          rem_sh, rem_sub;
  logic                rem_ge;
  logic signed [W+1:0] base_ext, quo_ext, sum;
  logic                quo_big;
  logic signed [W-1:0] clip;

  always_comb begin
    c1 = outcode(x1_q, y1_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
    c2 = outcode(x2_q, y2_q, win_left_q, win_right_q, win_bottom_q, win_top_q);
    co = (c1 != '0) ? c1 : c2;

    // Top and bottom edges solve for x; right and left solve for y.
    horiz = (edge_q & (lsc_pkg::OcTop | lsc_pkg::OcBottom)) != '0;
    if (edge_q == lsc_pkg::OcTop)         edge_val = win_top_q;
    else if (edge_q == lsc_pkg::OcBottom) edge_val = win_bottom_q;
    else if (edge_q == lsc_pkg::OcRight)  edge_val = win_right_q;
    else                                  edge_val = win_left_q;
    base = horiz ? x1_q : y1_q;

    dx    = (W+1)'(x2_q) - (W+1)'(x1_q);
    dy    = (W+1)'(y2_q) - (W+1)'(y1_q);
    dn    = (W+1)'(edge_val) - (W+1)'(horiz ? y1_q : x1_q);
    d_sel = horiz ? dx : dy;
    q_sel = horiz ? dy : dx;

    // Restoring divide step.
    rem_sh  = {rem_q, div_q[PW-1]};
    rem_ge  = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};

    // Apply quotient to base and saturate.
    quo_big  = div_q[PW-1:W] != '0;
    base_ext = (W+2)'(base);
    quo_ext  = {2'b00, div_q[W-1:0]};
    sum      = neg_q ? (base_ext - quo_ext) : (base_ext + quo_ext);
    if (quo_big)                          clip = neg_q ? CoordMin : CoordMax;
    else if (sum > (W+2)'(CoordMax))      clip = CoordMax;
    else if (sum < (W+2)'(CoordMin))      clip = CoordMin;
    else                                  clip = sum[W-1:0];
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    edge_d      = edge_q;
    first_d     = first_q;
    acc_d       = acc_q;
    pass_d      = pass_q;
    mag_a_d     = mag_a_q;
    mag_b_d     = mag_b_q;
    den_d       = den_q;
    neg_d       = neg_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_sx_d    = out_sx_q;
    out_sy_d    = out_sy_q;
    out_ex_d    = out_ex_q;
    out_ey_d    = out_ey_q;

    // Drop the result word once the sink takes it.
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      lsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          x1_d    = start_x_i;
          y1_d    = start_y_i;
          x2_d    = end_x_i;
          y2_d    = end_y_i;
          pass_d  = '0;
          state_d = lsc_pkg::ST_CODE;
        end
      end
      lsc_pkg::ST_CODE: begin
        if ((c1 | c2) == '0) begin
          acc_d   = 1'b1;
          state_d = lsc_pkg::ST_FINISH;
        end else if ((c1 & c2) != '0 || pass_q == lsc_pkg::PassLimit) begin
          acc_d   = 1'b0;
          state_d = lsc_pkg::ST_FINISH;
        end else begin
          first_d = c1 != '0;
          if ((co & lsc_pkg::OcTop) != '0)         edge_d = lsc_pkg::OcTop;
          else if ((co & lsc_pkg::OcBottom) != '0) edge_d = lsc_pkg::OcBottom;
          else if ((co & lsc_pkg::OcRight) != '0)  edge_d = lsc_pkg::OcRight;
          else                                     edge_d = lsc_pkg::OcLeft;
          state_d = lsc_pkg::ST_SETUP;
        end
      end
      lsc_pkg::ST_SETUP: begin
        mag_a_d = W'(d_sel[W] ? -d_sel : d_sel);
        mag_b_d = W'(dn[W] ? -dn : dn);
        den_d   = W'(q_sel[W] ? -q_sel : q_sel);
        neg_d   = d_sel[W] ^ dn[W] ^ q_sel[W];
        state_d = lsc_pkg::ST_MUL;
      end
      lsc_pkg::ST_MUL: begin
        rem_d = '0;
        cnt_d = '0;
        // A zero divisor leaves the base unchanged.
        if (den_q == '0) begin
          div_d   = '0;
          state_d = lsc_pkg::ST_APPLY;
        end else begin
          div_d   = mag_a_q * mag_b_q;
          state_d = lsc_pkg::ST_DIV;
        end
      end
      lsc_pkg::ST_DIV: begin
        rem_d = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        div_d = {div_q[PW-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(PW - 1)) state_d = lsc_pkg::ST_APPLY;
      end
      lsc_pkg::ST_APPLY: begin
        if (first_q) begin
          x1_d = horiz ? clip : edge_val;
          y1_d = horiz ? edge_val : clip;
        end else begin
          x2_d = horiz ? clip : edge_val;
          y2_d = horiz ? edge_val : clip;
        end
        pass_d  = pass_q + 1'b1;
        state_d = lsc_pkg::ST_CODE;
      end
      lsc_pkg::ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_sx_d    = acc_q ? x1_q : '0;
          out_sy_d    = acc_q ? y1_q : '0;
          out_ex_d    = acc_q ? x2_q : '0;
          out_ey_d    = acc_q ? y2_q : '0;
          state_d     = lsc_pkg::ST_IDLE;
        end
      end
      default: state_d = lsc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsc_pkg::ST_IDLE;
      pass_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x1_q      <= x1_d;
    y1_q      <= y1_d;
    x2_q      <= x2_d;
    y2_q      <= y2_d;
    edge_q    <= edge_d;
    first_q   <= first_d;
    acc_q     <= acc_d;
    mag_a_q   <= mag_a_d;
    mag_b_q   <= mag_b_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    out_acc_q <= out_acc_d;
    out_sx_q  <= out_sx_d;
    out_sy_q  <= out_sy_d;
    out_ex_q  <= out_ex_d;
    out_ey_q  <= out_ey_d;
  end

  assign in_stall_o        = state_q != lsc_pkg::ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign clipped_start_x_o = out_sx_q;
  assign clipped_start_y_o = out_sy_q;
  assign clipped_end_x_o   = out_ex_q;
  assign clipped_end_y_o   = out_ey_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `LSC_ASSERT(a_pass_bound, pass_q <= lsc_pkg::PassLimit, "clip pass count overran its limit")
  `LSC_ASSERT_IMP(a_rem_bound, state_q == lsc_pkg::ST_DIV, rem_q < den_q, "divider remainder not below divisor")
  `LSC_ASSERT_IMP(a_reject_zero, out_valid_q && !out_acc_q, out_sx_q == '0 && out_sy_q == '0 && out_ex_q == '0 && out_ey_q == '0, "rejected word carries nonzero coordinates")
  `LSC_ASSERT_NXT(a_accept_code, in_valid_i && !in_stall_o, state_q == lsc_pkg::ST_CODE, "accepted segment did not start outcode check")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line segment clipper testbench
// Sends segments through the clipper under several window settings and
// idle/stall patterns, and checks every result word against a local
// Cohen-Sutherland clipping predictor.
// ---------------------------------------------------------------------------

module tb_top;

  localparam int CW = lsc_pkg::CoordWidthDef;
  localparam longint CoordMax = (longint'(1) << (CW - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  // Quotient magnitude cap in the predictor's intersection step.
  localparam logic [127:0] QuotCap = 128'd1 << 40;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  typedef struct {
    logic   accepted;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  // Clock, reset and every DUT input start at known values.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [lsc_pkg::AddrW-1:0]  paddr = '0;
  logic [lsc_pkg::DataW-1:0]  pwdata = '0;
  logic [lsc_pkg::DataW-1:0]  prdata;
  logic                       pready;

  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;

  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  logic   accepted_o;
  coord_t clipped_start_x_o;
  coord_t clipped_start_y_o;
  coord_t clipped_end_x_o;
  coord_t clipped_end_y_o;

  // Segments waiting to be sent, and clip results waiting to come back.
  seg_t  pending_segs[$];
  clip_t expected_clips[$];

  // Window as the predictor sees it, indexed by register code.
  longint win_cfg[4] = '{lsc_pkg::WinLeftRst, lsc_pkg::WinBottomRst,
                         lsc_pkg::WinRightRst, lsc_pkg::WinTopRst};

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  line_segment_clipper dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

  always #4 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Clipping predictor
  // -------------------------------------------------------------------------

  function automatic longint sat_coord(longint v);
    if (v < CoordMin) return CoordMin;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  // Left/right and bottom/top are exclusive: left and bottom win the test.
  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] code;
    code = '0;
    if (x < win_cfg[lsc_pkg::REG_LEFT]) code |= lsc_pkg::OcLeft;
    else if (x > win_cfg[lsc_pkg::REG_RIGHT]) code |= lsc_pkg::OcRight;
    if (y < win_cfg[lsc_pkg::REG_BOTTOM]) code |= lsc_pkg::OcBottom;
    else if (y > win_cfg[lsc_pkg::REG_TOP]) code |= lsc_pkg::OcTop;
    return code;
  endfunction

  // base + d*n/q with the quotient truncated toward zero, capped in magnitude,
  // and the sum saturated to the coordinate range. A zero divisor adds nothing.
  function automatic longint edge_cross(longint base, longint d, longint n, longint q);
    logic [63:0]  mag_d, mag_n, mag_q;
    logic [127:0] prod, quo;
    logic         neg;
    mag_d = (d < 0) ? -d : d;
    mag_n = (n < 0) ? -n : n;
    mag_q = (q < 0) ? -q : q;
    neg = ((d < 0) != (n < 0)) != (q < 0);
    if (mag_q == 64'd0) return sat_coord(base);
    prod = {64'd0, mag_d} * {64'd0, mag_n};
    quo = prod / {64'd0, mag_q};
    if (quo > QuotCap) quo = QuotCap;
    return sat_coord(neg ? base - longint'(quo[63:0]) : base + longint'(quo[63:0]));
  endfunction

  function automatic clip_t clip_segment(seg_t seg);
    longint     x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, co;
    clip_t      res;
    x1 = seg.sx;
    y1 = seg.sy;
    x2 = seg.ex;
    y2 = seg.ey;
    c1 = region_code(x1, y1);
    c2 = region_code(x2, y2);
    res = '{default: '0};
    for (int pass = 0; pass <= lsc_pkg::PassLimit; pass++) begin
      if ((c1 | c2) == 4'd0) begin
        res.accepted = 1'b1;
        res.sx = x1[CW-1:0];
        res.sy = y1[CW-1:0];
        res.ex = x2[CW-1:0];
        res.ey = y2[CW-1:0];
        break;
      end
      // Drop the segment on a shared outside bit, or when passes run out.
      if ((c1 & c2) != 4'd0 || pass == lsc_pkg::PassLimit) break;
      co = (c1 != 4'd0) ? c1 : c2;
      if ((co & lsc_pkg::OcTop) != 4'd0) begin
        nx = edge_cross(x1, x2 - x1, win_cfg[lsc_pkg::REG_TOP] - y1, y2 - y1);
        ny = win_cfg[lsc_pkg::REG_TOP];
      end else if ((co & lsc_pkg::OcBottom) != 4'd0) begin
        nx = edge_cross(x1, x2 - x1, win_cfg[lsc_pkg::REG_BOTTOM] - y1, y2 - y1);
        ny = win_cfg[lsc_pkg::REG_BOTTOM];
      end else if ((co & lsc_pkg::OcRight) != 4'd0) begin
        ny = edge_cross(y1, y2 - y1, win_cfg[lsc_pkg::REG_RIGHT] - x1, x2 - x1);
        nx = win_cfg[lsc_pkg::REG_RIGHT];
      end else begin
        ny = edge_cross(y1, y2 - y1, win_cfg[lsc_pkg::REG_LEFT] - x1, x2 - x1);
        nx = win_cfg[lsc_pkg::REG_LEFT];
      end
      if (c1 != 4'd0) begin
        x1 = nx;
        y1 = ny;
        c1 = region_code(x1, y1);
      end else begin
        x2 = nx;
        y2 = ny;
        c2 = region_code(x2, y2);
      end
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Segment driver: present queued words, hold a stalled word unchanged, and
  // record the expected clip result at each accepted word.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      start_x_i <= '0;
      start_y_i <= '0;
      end_x_i <= '0;
      end_y_i <= '0;
    end else begin
      seg_t taken;
      seg_t next_seg;
      if (in_valid_i && !in_stall_o) begin
        taken = '{start_x_i, start_y_i, end_x_i, end_y_i};
        expected_clips.push_back(clip_segment(taken));
      end
      if (in_valid_i && in_stall_o) begin
        // Hold: the word stays on the bus until it is taken.
      end else if (pending_segs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_seg = pending_segs.pop_front();
        in_valid_i <= 1'b1;
        start_x_i <= next_seg.sx;
        start_y_i <= next_seg.sy;
        end_x_i <= next_seg.ex;
        end_y_i <= next_seg.ey;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor: compare each accepted result word with the oldest
  // expectation, then pick the stall for the next cycle.
  // -------------------------------------------------------------------------
  task automatic report_field(string field, coord_t want, coord_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    clip_t want;
    if (expected_clips.size() == 0) begin
      $display("%0t: unexpected result word, accepted %0b (%0d,%0d)-(%0d,%0d)", $time,
               accepted_o, clipped_start_x_o, clipped_start_y_o, clipped_end_x_o,
               clipped_end_y_o);
      mismatch_count++;
    end else begin
      want = expected_clips.pop_front();
      report_field("accepted", coord_t'(want.accepted), coord_t'(accepted_o));
      report_field("clipped_start_x", want.sx, clipped_start_x_o);
      report_field("clipped_start_y", want.sy, clipped_start_y_o);
      report_field("clipped_end_x", want.ex, clipped_end_x_o);
      report_field("clipped_end_y", want.ey, clipped_end_y_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // APB write: setup cycle, then access until pready. Upper data bits are
  // random, since only the low coordinate bits belong to the register.
  task automatic write_window(lsc_pkg::lsc_reg_e idx, coord_t value);
    logic [lsc_pkg::DataW-1:0] word;
    word = $urandom();
    word[CW-1:0] = value;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_cfg[idx] = value;
  endtask

  task automatic set_window(longint left, longint bottom, longint right, longint top);
    write_window(lsc_pkg::REG_LEFT, coord_t'(left));
    write_window(lsc_pkg::REG_BOTTOM, coord_t'(bottom));
    write_window(lsc_pkg::REG_RIGHT, coord_t'(right));
    write_window(lsc_pkg::REG_TOP, coord_t'(top));
  endtask

  // Random window: mostly up to 3000 units wide, sometimes up to 65535;
  // swap the bounds to get an inverted window.
  task automatic random_window(bit inverted);
    longint lo[2], hi[2], span;
    for (int axis = 0; axis < 2; axis++) begin
      span = int'($urandom_range(0, 3000));
      if ($urandom_range(3) == 0) span = int'($urandom_range(0, 65535));
      lo[axis] = CoordMin + int'($urandom_range(0, 65535 - span));
      hi[axis] = lo[axis] + span;
    end
    if (inverted) set_window(hi[0], hi[1], lo[0], lo[1]);
    else set_window(lo[0], lo[1], hi[0], hi[1]);
  endtask

  task automatic add_seg(int sx, int sy, int ex, int ey);
    pending_segs.push_back('{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)});
  endtask

  // Coordinate on one axis: any bit pattern, near the window span, or within
  // three units of one of its edges.
  function automatic coord_t pick_coord(longint a, longint b);
    longint lo, hi, margin;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(9))
      0, 1: return coord_t'($urandom());
      2, 3, 4, 5, 6: begin
        margin = (hi - lo) / 2 + 16;
        return coord_t'(sat_coord(lo - margin +
                                  int'($urandom_range(0, hi - lo + 2 * margin))));
      end
      default: return coord_t'(sat_coord(($urandom_range(1) ? lo : hi) +
                                         int'($urandom_range(0, 6)) - 3));
    endcase
  endfunction

  // Sample on the falling edge, after the driver and monitor have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_segs.size() != 0 || in_valid_i || expected_clips.size() != 0);
  endtask

  // Queue n random segments for the current window and run them to the end;
  // the sender stays quiet until the last result is back.
  task automatic run_random(int n, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      pending_segs.push_back('{
        pick_coord(win_cfg[lsc_pkg::REG_LEFT], win_cfg[lsc_pkg::REG_RIGHT]),
        pick_coord(win_cfg[lsc_pkg::REG_BOTTOM], win_cfg[lsc_pkg::REG_TOP]),
        pick_coord(win_cfg[lsc_pkg::REG_LEFT], win_cfg[lsc_pkg::REG_RIGHT]),
        pick_coord(win_cfg[lsc_pkg::REG_BOTTOM], win_cfg[lsc_pkg::REG_TOP])});
    end
    wait_idle();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window 100..300 on both axes.
    add_seg(150, 150, 250, 250);        // fully inside
    add_seg(0, 0, 50, 50);              // shared left and bottom bits
    add_seg(350, 150, 400, 250);        // right of window
    add_seg(150, 350, 250, 400);        // above window
    add_seg(150, 0, 250, 50);           // below window
    add_seg(50, 200, 350, 200);         // horizontal through left and right
    add_seg(200, 50, 200, 350);         // vertical through bottom and top
    add_seg(0, 0, 400, 400);            // diagonal, clipped at both ends
    add_seg(0, 250, 150, 400);          // misses the corner after clipping
    add_seg(250, 400, 350, 250);        // clipped at top, then rejected right of window
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-32768, 200, 32767, 200);
    add_seg(100, 100, 300, 300);        // corner to corner, on the edges
    add_seg(99, 100, 301, 300);         // one unit outside on x
    add_seg(200, 200, 200, 200);        // point inside
    add_seg(50, 50, 50, 50);            // point outside
    add_seg(-1, -1, -1, -1);
    add_seg(0, 0, 0, 0);
    wait_idle();

    // Full coordinate range: everything lands inside.
    set_window(CoordMin, CoordMin, CoordMax, CoordMax);
    add_seg(-32768, 32767, 32767, -32768);
    add_seg(32767, 32767, 32767, 32767);
    wait_idle();

    // Inverted windows: never settle, so the pass limit and saturation show.
    set_window(CoordMax, CoordMax, CoordMin, CoordMin);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    wait_idle();
    set_window(300, 300, 100, 100);
    add_seg(0, 400, 400, 0);
    add_seg(200, 200, 250, 250);
    wait_idle();

    // Random traffic under the idle and stall patterns.
    set_window(lsc_pkg::WinLeftRst, lsc_pkg::WinBottomRst,
               lsc_pkg::WinRightRst, lsc_pkg::WinTopRst);
    run_random(250, 0, 0);
    random_window(1'b0);
    run_random(200, 46, 0);
    random_window(1'b0);
    run_random(200, 0, 46);
    random_window(1'b0);
    run_random(200, 13, 13);
    random_window(1'b1);
    run_random(120, 0, 0);
    set_window(CoordMin, CoordMin, CoordMax, CoordMax);
    run_random(100, 13, 13);
    random_window(1'b0);
    run_random(200, 46, 46);

    // Let any stray result word show up before the verdict.
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
